@@ hdl/ct_pkg.sv @@
// ----------------------------------------------------------------------------
// ct_pkg
// Shared types and codes for the credential table: request and response
// items, action and status codes, default sizes.
// ----------------------------------------------------------------------------
package ct_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int ID_BITS_DEF = 64;
	localparam int TAG_W       = 64;
	localparam int SLOT_IDX_W  = 4;

	localparam logic [1:0] ACT_CHECK  = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_DUPLICATE = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]       action;
		logic [TAG_W-1:0] tag_id;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [SLOT_IDX_W-1:0] slot_index;
	} rsp_t;

endpackage

@@ hdl/credential_table.sv @@
// ----------------------------------------------------------------------------
// credential_table
// Table of enrolled tag IDs with a valid bit per slot. Check, add and remove
// requests scan every slot of the tag memory, one read per cycle.
// ----------------------------------------------------------------------------
// result strobe: registered from the done state, which follows the scan state
// a new item is taken only in idle; busy covers the one-read-per-cycle
//   scan of the tag memory and the done update
// done pulses for one cycle; the receiver cannot stall; rsp holds until a later result
// reset clears all valid bits at once; tag memory is not cleared
module credential_table #(
	parameter int SLOTS   = ct_pkg::SLOTS_DEF,
	parameter int ID_BITS = ct_pkg::ID_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  ct_pkg::req_t req,
	output logic         done,
	output ct_pkg::rsp_t rsp
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = SLOT_W + 1;
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	logic [ID_BITS-1:0] mem [SLOTS];
	logic [SLOTS-1:0]   slot_valid_q;

	logic [1:0]         action_q;
	logic [ID_BITS-1:0] id_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic [SLOT_W-1:0]  rd_addr;
	logic               rd_vld_s1;
	logic [SLOT_W-1:0]  rd_addr_s1;
	logic [ID_BITS-1:0] rd_data_s1;

	logic               hit_found_q;
	logic [SLOT_W-1:0]  hit_idx_q;
	logic               free_found_q;
	logic [SLOT_W-1:0]  free_idx_q;

	logic               done_q;
	ct_pkg::rsp_t       rsp_q;

	logic               accept;
	logic               cmp_hit;
	logic               cmp_free;
	logic               is_add;
	logic               is_remove;
	logic               add_ok;
	logic               remove_ok;
	logic [1:0]         res_status;
	logic [SLOT_W-1:0]  res_idx;
	logic [SLOT_W+ct_pkg::SLOT_IDX_W-1:0] res_idx_ext;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign rd_addr = rd_cnt_q[SLOT_W-1:0];

	assign cmp_hit  = rd_vld_s1 && slot_valid_q[rd_addr_s1] && (rd_data_s1 == id_q);
	assign cmp_free = rd_vld_s1 && !slot_valid_q[rd_addr_s1];

	assign is_add    = (action_q == ct_pkg::ACT_ADD);
	assign is_remove = (action_q == ct_pkg::ACT_REMOVE);
	assign add_ok    = is_add && free_found_q && !hit_found_q;
	assign remove_ok = is_remove && hit_found_q;

	always_comb begin
		res_status = ct_pkg::STAT_NOT_FOUND;
		res_idx    = '0;
		if (is_add) begin
			if (!free_found_q) begin
				res_status = ct_pkg::STAT_FULL;
			end else if (hit_found_q) begin
				res_status = ct_pkg::STAT_DUPLICATE;
				res_idx    = hit_idx_q;
			end else begin
				res_status = ct_pkg::STAT_OK;
				res_idx    = free_idx_q;
			end
		end else if (hit_found_q) begin
			res_status = ct_pkg::STAT_OK;
			res_idx    = hit_idx_q;
		end
	end

	assign res_idx_ext = {{ct_pkg::SLOT_IDX_W{1'b0}}, res_idx};

	// tag memory: one read port for the scan, one write at update
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && rd_cnt_q != CNT_END) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (state_q == ST_DONE && add_ok) begin
			mem[free_idx_q] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_valid_q <= '0;
			rd_cnt_q     <= '0;
			rd_vld_s1    <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DONE);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cnt_q     <= '0;
						rd_vld_s1    <= 1'b0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_cnt_q != CNT_END) begin
						rd_cnt_q  <= rd_cnt_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_DONE;
					end
					if (cmp_hit && !hit_found_q) begin
						hit_found_q <= 1'b1;
					end
					if (cmp_free && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
				ST_DONE: begin
					if (add_ok) begin
						slot_valid_q[free_idx_q] <= 1'b1;
					end
					if (remove_ok) begin
						slot_valid_q[hit_idx_q] <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload, match index and response registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= req.action;
			id_q     <= req.tag_id[ID_BITS-1:0];
		end
		rd_addr_s1 <= rd_addr;
		if (state_q == ST_SCAN && cmp_hit && !hit_found_q) begin
			hit_idx_q <= rd_addr_s1;
		end
		if (state_q == ST_SCAN && cmp_free && !free_found_q) begin
			free_idx_q <= rd_addr_s1;
		end
		if (state_q == ST_DONE) begin
			rsp_q.status     <= res_status;
			rsp_q.slot_index <= res_idx_ext[ct_pkg::SLOT_IDX_W-1:0];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe outside idle");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN) && !hit_found_q && !free_found_q)
		else $error("accepted item did not start a clean scan");

	a_rd_vld_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("compare stage active outside scan");

	a_add_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && add_ok) |=> slot_valid_q[$past(free_idx_q)])
		else $error("added slot not marked valid");
`endif

endmodule
